FILE: src/sws_pkg.sv
// sws_pkg: shared widths, input mode codes, register indexes and the scan response type
// for the sliding window sequence scorer; no dependencies
package sws_pkg;

	localparam int MODE_W     = 2;
	localparam int STATE_W    = 4;
	localparam int ROW_W      = 5;
	localparam int VALUE_W    = 8;
	localparam int HIT_W      = 7;
	localparam int REF_W      = 7;
	localparam int THR_W      = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH       = 2'd0,
		MODE_LOAD_MASK  = 2'd1,
		MODE_LOAD_LIMIT = 2'd2,
		MODE_CLEAR      = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_HITS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BELONG_THRESHOLD = 1'b1;

	localparam logic [REF_W-1:0] REF_HITS_RESET  = 7'd64;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 9'd192;

	typedef struct packed {
		logic             done;
		logic [HIT_W-1:0] hits;
	} scan_rsp_t;

endpackage

FILE: src/sws_if.sv
// sws_in_if and sws_out_if: valid/ready channels for sample words and score words
// depends on sws_pkg for the field widths
interface sws_in_if import sws_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [STATE_W-1:0] sample_state;
	logic [ROW_W-1:0]   row_index;
	logic [VALUE_W-1:0] entry_value;

	modport source (output valid, output mode, output sample_state, output row_index,
		output entry_value, input ready);
	modport sink (input valid, input mode, input sample_state, input row_index,
		input entry_value, output ready);
endinterface

interface sws_out_if import sws_pkg::*; ;
	logic             valid;
	logic             ready;
	logic             window_full;
	logic [HIT_W-1:0] hit_count;
	logic             belongs;

	modport source (output valid, output window_full, output hit_count, output belongs,
		input ready);
	modport sink (input valid, input window_full, input hit_count, input belongs,
		output ready);
endinterface

FILE: src/sliding_window_sequence_scorer.sv
// sliding_window_sequence_scorer: top level with window, mask and limit rams and control
// depends on sws_pkg, sws_if, sws_ram and sws_scan
//
// sample_ch takes one word per item: mode selects a push of sample_state, a mask bit load
// (row_index is the window position), a transition limit load (row_index is the source
// state) or a window clear. score_ch gives one word for every push and none otherwise.
// cfg_we/cfg_index/cfg_data write reference_hits (index 0) and belong_threshold_q8 (1).
// loads and clears do not lower sample_ch.ready. a push that leaves the window short of full
// gives an all zero word through the pend and output registers, and the next item is taken
// once it is in the output register. a push that fills or slides the window starts a scoring
// pass: one window position is read per cycle through the window ram, then the mask, limit
// and usage rams, and the word then goes through the same pend and output registers.
// sample_ch.ready is low while a push is being handled. the result sits in an output
// register, so when score_ch stalls the block still takes loads and clears, and a further
// push is scored but waits until the earlier word has been taken.
// reset empties the window and sets the registers to 64 and 192; the mask and limit rams
// hold nothing defined until loaded.
module sliding_window_sequence_scorer import sws_pkg::*; #(
	parameter int WINDOW_LEN = 32,
	parameter int NUM_STATES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sws_in_if.sink                sample_ch,
	sws_out_if.source             score_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW = $clog2(WINDOW_LEN);
	localparam int SW = $clog2(NUM_STATES);
	localparam int FW = $clog2(WINDOW_LEN + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PEND
	} state_t;

	state_t            state_q;
	logic [FW-1:0]     fill_q;
	logic [PW-1:0]     head_q, head_wrap;
	logic [REF_W-1:0]  ref_q;
	logic [THR_W-1:0]  thr_q;
	logic              pend_full_q, pend_belongs_q;
	logic [HIT_W-1:0]  pend_hits_q;
	logic              out_valid_q, out_full_q, out_belongs_q;
	logic [HIT_W-1:0]  out_hits_q;

	logic              accept, is_push, filling, scan_start;
	mode_t             mode;
	logic [PW-1:0]     scan_head, win_waddr, win_raddr;
	logic [STATE_W-1:0] win_rdata;
	logic              mask_we, mask_rdata;
	logic [PW+SW-1:0]  mask_waddr, mask_raddr;
	logic              limit_we;
	logic [2*SW-1:0]   limit_waddr, limit_raddr;
	logic [VALUE_W-1:0] limit_rdata;
	scan_rsp_t         rsp;
	logic [THR_W+REF_W-1:0] thr_ref, hits_scaled;
	logic              belongs_c;

	assign sample_ch.ready = state_q == ST_IDLE;
	assign accept  = sample_ch.valid && sample_ch.ready;
	assign mode    = mode_t'(sample_ch.mode);
	assign is_push = accept && mode == MODE_PUSH;
	assign filling = fill_q < FW'(WINDOW_LEN);

	assign head_wrap  = (head_q == PW'(WINDOW_LEN - 1)) ? '0 : head_q + 1'b1;
	assign win_waddr  = filling ? fill_q[PW-1:0] : head_q;
	assign scan_start = is_push && (!filling || fill_q == FW'(WINDOW_LEN - 1));
	assign scan_head  = filling ? head_q : head_wrap;

	assign mask_we = accept && mode == MODE_LOAD_MASK
		&& ({1'b0, sample_ch.row_index} < (ROW_W+1)'(WINDOW_LEN))
		&& ({1'b0, sample_ch.sample_state} < (STATE_W+1)'(NUM_STATES));
	assign mask_waddr = {sample_ch.row_index[PW-1:0], sample_ch.sample_state[SW-1:0]};

	assign limit_we = accept && mode == MODE_LOAD_LIMIT
		&& ({1'b0, sample_ch.row_index} < (ROW_W+1)'(NUM_STATES))
		&& ({1'b0, sample_ch.sample_state} < (STATE_W+1)'(NUM_STATES));
	assign limit_waddr = {sample_ch.row_index[SW-1:0], sample_ch.sample_state[SW-1:0]};

	sws_ram #(
		.WIDTH(STATE_W),
		.DEPTH(WINDOW_LEN)
	) u_window_ram (
		.clk  (clk),
		.we   (is_push),
		.waddr(win_waddr),
		.wdata(sample_ch.sample_state),
		.raddr(win_raddr),
		.rdata(win_rdata)
	);

	sws_ram #(
		.WIDTH(1),
		.DEPTH(2 ** (PW + SW))
	) u_mask_ram (
		.clk  (clk),
		.we   (mask_we),
		.waddr(mask_waddr),
		.wdata(sample_ch.entry_value[0]),
		.raddr(mask_raddr),
		.rdata(mask_rdata)
	);

	sws_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(2 ** (2 * SW))
	) u_limit_ram (
		.clk  (clk),
		.we   (limit_we),
		.waddr(limit_waddr),
		.wdata(sample_ch.entry_value),
		.raddr(limit_raddr),
		.rdata(limit_rdata)
	);

	sws_scan #(
		.WINDOW_LEN(WINDOW_LEN),
		.NUM_STATES(NUM_STATES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.head       (scan_head),
		.win_raddr  (win_raddr),
		.win_rdata  (win_rdata),
		.mask_raddr (mask_raddr),
		.mask_rdata (mask_rdata),
		.limit_raddr(limit_raddr),
		.limit_rdata(limit_rdata),
		.rsp        (rsp)
	);

	// hits <= ref and hits * 256 >= threshold * ref
	assign thr_ref     = thr_q * ref_q;
	assign hits_scaled = {1'b0, rsp.hits, 8'b0};
	assign belongs_c   = (rsp.hits <= ref_q) && (hits_scaled >= thr_ref);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_HITS_RESET;
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REFERENCE_HITS: ref_q <= cfg_data[REF_W-1:0];
				REG_BELONG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			head_q         <= '0;
			pend_full_q    <= 1'b0;
			pend_hits_q    <= '0;
			pend_belongs_q <= 1'b0;
			out_valid_q    <= 1'b0;
			out_full_q     <= 1'b0;
			out_hits_q     <= '0;
			out_belongs_q  <= 1'b0;
		end else begin
			if (out_valid_q && score_ch.ready && state_q != ST_PEND) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_PUSH: begin
								if (filling) begin
									fill_q <= fill_q + 1'b1;
								end else begin
									head_q <= head_wrap;
								end
								if (scan_start) begin
									state_q <= ST_SCAN;
								end else begin
									pend_full_q    <= 1'b0;
									pend_hits_q    <= '0;
									pend_belongs_q <= 1'b0;
									state_q        <= ST_PEND;
								end
							end
							MODE_CLEAR: begin
								fill_q <= '0;
								head_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (rsp.done) begin
						pend_full_q    <= 1'b1;
						pend_hits_q    <= rsp.hits;
						pend_belongs_q <= belongs_c;
						state_q        <= ST_PEND;
					end
				end
				ST_PEND: begin
					// hand over once the output register is free
					if (!out_valid_q || score_ch.ready) begin
						out_valid_q   <= 1'b1;
						out_full_q    <= pend_full_q;
						out_hits_q    <= pend_hits_q;
						out_belongs_q <= pend_belongs_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign score_ch.valid       = out_valid_q;
	assign score_ch.window_full = out_full_q;
	assign score_ch.hit_count   = out_hits_q;
	assign score_ch.belongs     = out_belongs_q;

endmodule

FILE: src/sws_ram.sv
// sws_ram: generic simple dual port ram, one write port, one read port with registered data
// no dependencies
module sws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/sws_scan.sv
// sws_scan: scoring pass over the window, three stage read pipeline with a usage ram
// depends on sws_pkg and sws_ram; window, mask and limit rams sit in the top level
module sws_scan import sws_pkg::*; #(
	parameter int WINDOW_LEN = 32,
	parameter int NUM_STATES = 16,
	localparam int PW = $clog2(WINDOW_LEN),
	localparam int SW = $clog2(NUM_STATES),
	localparam int PAIR_W = 2 * SW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PW-1:0]      head,
	output logic [PW-1:0]      win_raddr,
	input  logic [STATE_W-1:0] win_rdata,
	output logic [PW+SW-1:0]   mask_raddr,
	input  logic               mask_rdata,
	output logic [PAIR_W-1:0]  limit_raddr,
	input  logic [VALUE_W-1:0] limit_rdata,
	output scan_rsp_t          rsp
);

	localparam int PAIRS = 2 ** PAIR_W;

	// issue stage
	logic          active_q;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] head_q;
	logic [PW:0]   addr_sum;

	// stage 1: window state arrives
	logic              v_s1, first_s1, last_s1;
	logic [PW-1:0]     pos_s1;
	logic [STATE_W-1:0] prev_q;
	logic              prev_ok_q;
	logic              cur_ok;
	logic [PAIR_W-1:0] pair;

	// stage 2: mask, limit and usage arrive
	logic              v_s2, last_s2, pos_ok_s2, tr_ok_s2;
	logic [PAIR_W-1:0] pair_s2;
	logic [PW-1:0]     use_rdata, used;
	logic              pos_hit, tr_hit;
	logic [HIT_W-1:0]  hits_q, hits_nxt;
	logic [PAIRS-1:0]  uvalid_q;
	logic              fwd_v_q;
	logic [PAIR_W-1:0] fwd_pair_q;
	logic [PW-1:0]     fwd_val_q;

	assign addr_sum  = {1'b0, head_q} + {1'b0, idx_q};
	assign win_raddr = (addr_sum >= (PW+1)'(WINDOW_LEN))
		? PW'(addr_sum - (PW+1)'(WINDOW_LEN)) : addr_sum[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			head_q   <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
			head_q   <= head;
		end else if (active_q) begin
			if (idx_q == PW'(WINDOW_LEN - 1)) begin
				active_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	assign cur_ok      = {1'b0, win_rdata} < (STATE_W+1)'(NUM_STATES);
	assign mask_raddr  = {pos_s1, win_rdata[SW-1:0]};
	assign pair        = {prev_q[SW-1:0], win_rdata[SW-1:0]};
	assign limit_raddr = pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			first_s1  <= 1'b0;
			last_s1   <= 1'b0;
			pos_s1    <= '0;
			prev_q    <= '0;
			prev_ok_q <= 1'b0;
			v_s2      <= 1'b0;
			last_s2   <= 1'b0;
			pos_ok_s2 <= 1'b0;
			tr_ok_s2  <= 1'b0;
			pair_s2   <= '0;
		end else begin
			v_s1     <= active_q && !start;
			first_s1 <= idx_q == '0;
			last_s1  <= idx_q == PW'(WINDOW_LEN - 1);
			pos_s1   <= idx_q;
			if (v_s1) begin
				prev_q    <= win_rdata;
				prev_ok_q <= cur_ok;
			end
			v_s2      <= v_s1;
			last_s2   <= last_s1;
			pos_ok_s2 <= cur_ok;
			tr_ok_s2  <= !first_s1 && cur_ok && prev_ok_q;
			pair_s2   <= pair;
		end
	end

	// unused pairs count as zero; usage written last cycle is not yet in the ram read data
	always_comb begin
		if (!uvalid_q[pair_s2]) begin
			used = '0;
		end else if (fwd_v_q && fwd_pair_q == pair_s2) begin
			used = fwd_val_q;
		end else begin
			used = use_rdata;
		end
	end

	assign pos_hit  = v_s2 && pos_ok_s2 && mask_rdata;
	assign tr_hit   = v_s2 && tr_ok_s2 && (VALUE_W'(used) < limit_rdata);
	assign hits_nxt = hits_q + HIT_W'(pos_hit) + HIT_W'(tr_hit);

	sws_ram #(
		.WIDTH(PW),
		.DEPTH(PAIRS)
	) u_usage_ram (
		.clk  (clk),
		.we   (tr_hit),
		.waddr(pair_s2),
		.wdata(used + 1'b1),
		.raddr(pair),
		.rdata(use_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q     <= '0;
			uvalid_q   <= '0;
			fwd_v_q    <= 1'b0;
			fwd_pair_q <= '0;
			fwd_val_q  <= '0;
		end else begin
			fwd_v_q    <= tr_hit;
			fwd_pair_q <= pair_s2;
			fwd_val_q  <= used + 1'b1;
			if (start) begin
				hits_q   <= '0;
				uvalid_q <= '0;
			end else begin
				if (v_s2) begin
					hits_q <= hits_nxt;
				end
				if (tr_hit) begin
					uvalid_q[pair_s2] <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = v_s2 && last_s2;
	assign rsp.hits = hits_nxt;

endmodule

FILE: src/sws_checker.sv
// sws_checker: port level assertions for the sliding window sequence scorer
// depends on sws_pkg; bound to the top level at the end of this file
module sws_checker import sws_pkg::*; #(
	parameter int WINDOW_LEN = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [MODE_W-1:0] in_mode,
	input logic              out_valid,
	input logic              out_ready,
	input logic              window_full,
	input logic [HIT_W-1:0]  hit_count,
	input logic              belongs
);

	// a stalled score word keeps its contents
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({window_full, hit_count, belongs}))
		else $error("score word changed while stalled");

	// every push word is worked on before the next word is taken
	a_push_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_mode == MODE_PUSH |=> !in_ready)
		else $error("word taken straight after a push");

	// a window short of full scores nothing
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_full |-> hit_count == '0 && !belongs)
		else $error("score reported before window full");

	// at most one hit per position and one per transition
	a_hit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit_count <= HIT_W'(2 * WINDOW_LEN - 1))
		else $error("hit count above window bound");

endmodule

bind sliding_window_sequence_scorer sws_checker #(
	.WINDOW_LEN(WINDOW_LEN)
) u_sws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.in_mode    (sample_ch.mode),
	.out_valid  (score_ch.valid),
	.out_ready  (score_ch.ready),
	.window_full(score_ch.window_full),
	.hit_count  (score_ch.hit_count),
	.belongs    (score_ch.belongs)
);
